// ----- rtl/lip_pkg.sv -----
// lip_pkg: shared constants for the line intersection pipeline.
// No dependencies; used by every RTL file of the block.
package lip_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int FIELD_W        = 16;
  localparam int PARAM_W        = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam logic [PARAM_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [PARAM_W-1:0] NEG_LIMIT = 32'h8000_0000;
endpackage

// ----- rtl/lip_if.sv -----
// lip_in_if / lip_out_if: valid-ready channels for line pairs and results.
// Depends on lip_pkg for field widths.
interface lip_in_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [lip_pkg::FIELD_W-1:0] a_start_x, a_start_y, a_end_x, a_end_y;
  logic signed [lip_pkg::FIELD_W-1:0] b_start_x, b_start_y, b_end_x, b_end_y;
  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface lip_out_if (input logic clk);
  logic valid;
  logic ready;
  logic found;
  logic signed [lip_pkg::PARAM_W-1:0] param_a;
  logic signed [lip_pkg::PARAM_W-1:0] param_b;
  logic clipped;
  modport source (output valid, found, param_a, param_b, clipped, input ready);
  modport sink (input valid, found, param_a, param_b, clipped, output ready);
endinterface

// ----- rtl/lip_front.sv -----
// lip_front: accepts line pairs, forms differences, products, determinant
// and numerators; emits sign and magnitude words. Depends on lip_pkg, lip_if.
module lip_front #(
  parameter int COORD_BITS = lip_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  lip_in_if.sink             pairs,
  output logic               q_valid,
  input  logic               q_ready,
  output logic [3*(2*COORD_BITS+1)+2:0] q_word
);
  localparam int DW = COORD_BITS + 1;
  localparam int SW = 2 * COORD_BITS + 2;
  localparam int MW = 2 * COORD_BITS + 1;

  logic en;
  logic v1, v2, v3;
  logic signed [DW-1:0] vax, vay, vbx, vby, dx, dy;
  logic signed [SW-1:0] p0, p1, p2, p3, p4, p5;
  logic dz, na, nb;
  logic [MW-1:0] ma, mb, md;

  function automatic logic signed [DW-1:0] diff(input logic [lip_pkg::FIELD_W-1:0] e,
                                                input logic [lip_pkg::FIELD_W-1:0] s);
    logic signed [DW-1:0] ex, sx;
    ex = DW'($signed(e[COORD_BITS-1:0]));
    sx = DW'($signed(s[COORD_BITS-1:0]));
    return ex - sx;
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] t;
    t = x[SW-1] ? -x : x;
    return t[MW-1:0];
  endfunction

  assign en          = !v3 || q_ready;
  assign pairs.ready = en;
  assign q_valid     = v3;
  assign q_word      = {dz, na, nb, ma, mb, md};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= pairs.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vax <= diff(pairs.a_end_x, pairs.a_start_x);
      vay <= diff(pairs.a_end_y, pairs.a_start_y);
      vbx <= diff(pairs.b_end_x, pairs.b_start_x);
      vby <= diff(pairs.b_end_y, pairs.b_start_y);
      dx  <= diff(pairs.b_start_x, pairs.a_start_x);
      dy  <= diff(pairs.b_start_y, pairs.a_start_y);
      p0  <= vbx * vay;
      p1  <= vax * vby;
      p2  <= vbx * dy;
      p3  <= dx * vby;
      p4  <= vax * dy;
      p5  <= dx * vay;
      dz  <= (p0 - p1) == '0;
      na  <= (p2 - p3) < 0 != (p0 - p1) < 0;
      nb  <= (p4 - p5) < 0 != (p0 - p1) < 0;
      ma  <= mag(p2 - p3);
      mb  <= mag(p4 - p5);
      md  <= mag(p0 - p1);
    end
  end
endmodule

// ----- rtl/lip_fifo.sv -----
// lip_fifo: small word queue between the front and back pipelines.
// Depends on lip_pkg for the default depth.
module lip_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = lip_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [DEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0] count;
  logic push, pop;

  assign push_ready = count != (PW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rp];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end
endmodule

// ----- rtl/lip_back.sv -----
// lip_back: overflow precheck, 32-stage restoring divider pair, saturation.
// Depends on lip_pkg and lip_if.
module lip_back #(
  parameter int COORD_BITS = lip_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lip_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  logic [3*(2*COORD_BITS+1)+2:0] q_word,
  lip_out_if.source          result
);
  localparam int MW = 2 * COORD_BITS + 1;
  localparam int NW = MW + FRAC_BITS;
  localparam int QB = lip_pkg::PARAM_W;

  logic en;
  logic          sv  [QB+1];
  logic          sdz [QB+1];
  logic          sna [QB+1];
  logic          snb [QB+1];
  logic          soa [QB+1];
  logic          sob [QB+1];
  logic [MW-1:0] smd [QB+1];
  logic [MW-1:0] sra [QB+1];
  logic [MW-1:0] srb [QB+1];
  logic [QB-1:0] sla [QB+1];
  logic [QB-1:0] slb [QB+1];
  logic [QB-1:0] sqa [QB+1];
  logic [QB-1:0] sqb [QB+1];

  logic in_dz, in_na, in_nb;
  logic [MW-1:0] in_ma, in_mb, in_md;
  logic [NW+QB-1:0] ea, eb;
  logic [NW-1:0] ha, hb;

  assign {in_dz, in_na, in_nb, in_ma, in_mb, in_md} = q_word;
  assign en      = !result.valid || result.ready;
  assign q_ready = en;
  assign ea = (NW+QB)'(in_ma) << FRAC_BITS;
  assign eb = (NW+QB)'(in_mb) << FRAC_BITS;
  assign ha = ea[NW+QB-1:QB];
  assign hb = eb[NW+QB-1:QB];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= q_valid;
  end

  // quotient of 2^32 or more is decided up front
  always_ff @(posedge clk) begin
    if (en) begin
      sdz[0] <= in_dz;
      sna[0] <= in_na;
      snb[0] <= in_nb;
      smd[0] <= in_md;
      soa[0] <= ha >= NW'(in_md);
      sob[0] <= hb >= NW'(in_md);
      sra[0] <= ha[MW-1:0];
      srb[0] <= hb[MW-1:0];
      sla[0] <= ea[QB-1:0];
      slb[0] <= eb[QB-1:0];
      sqa[0] <= '0;
      sqb[0] <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [MW:0] ta, tb, da, db;
    logic ga, gb;
    always_comb begin
      ta = {sra[k], sla[k][QB-1]};
      tb = {srb[k], slb[k][QB-1]};
      ga = ta >= {1'b0, smd[k]};
      gb = tb >= {1'b0, smd[k]};
      da = ga ? ta - {1'b0, smd[k]} : ta;
      db = gb ? tb - {1'b0, smd[k]} : tb;
    end
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else if (en) sv[k+1] <= sv[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sdz[k+1] <= sdz[k];
        sna[k+1] <= sna[k];
        snb[k+1] <= snb[k];
        soa[k+1] <= soa[k];
        sob[k+1] <= sob[k];
        smd[k+1] <= smd[k];
        sra[k+1] <= da[MW-1:0];
        srb[k+1] <= db[MW-1:0];
        sla[k+1] <= sla[k] << 1;
        slb[k+1] <= slb[k] << 1;
        sqa[k+1] <= {sqa[k][QB-2:0], ga};
        sqb[k+1] <= {sqb[k][QB-2:0], gb};
      end
    end
  end

  logic sat_a, sat_b;
  logic [QB-1:0] va, vb;
  always_comb begin
    sat_a = soa[QB] || (sna[QB] ? sqa[QB] > lip_pkg::NEG_LIMIT : sqa[QB] > lip_pkg::POS_LIMIT);
    sat_b = sob[QB] || (snb[QB] ? sqb[QB] > lip_pkg::NEG_LIMIT : sqb[QB] > lip_pkg::POS_LIMIT);
    va = sat_a ? (sna[QB] ? lip_pkg::NEG_LIMIT : lip_pkg::POS_LIMIT) : sqa[QB];
    vb = sat_b ? (snb[QB] ? lip_pkg::NEG_LIMIT : lip_pkg::POS_LIMIT) : sqb[QB];
  end

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (en) result.valid <= sv[QB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.found   <= !sdz[QB];
      result.param_a <= sdz[QB] ? '0 : (sna[QB] ? -va : va);
      result.param_b <= sdz[QB] ? '0 : (snb[QB] ? -vb : vb);
      result.clipped <= !sdz[QB] && (sat_a || sat_b);
    end
  end
endmodule

// ----- rtl/line_intersection_params.sv -----
// line_intersection_params: top level, front pipeline, queue, divider back end.
// Depends on lip_pkg, lip_if, lip_front, lip_fifo, lip_back.
//
//   channel  dir  word
//   pairs    in   two segments, eight 16-bit signed coordinates
//   result   out  found, param_a, param_b (Q16.16), clipped
//
// One pair per cycle sustained unless result stalls. A pair passes the front
// registers, the queue, a precheck register, 32 divider stages (one quotient
// bit each) and the output reg; the divider stages set the latency. Reset
// is synchronous and clears all valid bits and the queue. A stall at result
// holds the back end; the queue keeps the front running until it fills.
module line_intersection_params #(
  parameter int COORD_BITS = lip_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lip_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  lip_in_if.sink    pairs,
  lip_out_if.source result
);
  localparam int QW = 3 * (2 * COORD_BITS + 1) + 3;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [QW-1:0] f_word, b_word;

  lip_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .pairs(pairs),
    .q_valid(f_valid), .q_ready(f_ready), .q_word(f_word)
  );

  lip_fifo #(.W(QW), .DEPTH(lip_pkg::QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_word),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_word)
  );

  lip_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(b_valid), .q_ready(b_ready), .q_word(b_word),
    .result(result)
  );

  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.found |->
      result.param_a == '0 && result.param_b == '0 && !result.clipped)
    else $error("parallel result not zero");

  a_reset_idle: assert property (@(posedge clk) rst |=> !result.valid && !b_valid)
    else $error("valid after reset");

  a_back_pull: assert property (@(posedge clk) disable iff (rst)
    b_ready |-> !result.valid || result.ready)
    else $error("back end pulls while stalled");
endmodule

// ----- tb/tb_lip_if.sv -----
// Testbench view of the pair and result channels.
// No dependencies; the RTL file lip_if.sv supplies the interfaces themselves.
package tb_lip_types;
  typedef struct packed {
    logic signed [15:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
  } pair_t;
  typedef struct packed {
    logic               found;
    logic signed [31:0] pa;
    logic signed [31:0] pb;
    logic               clipped;
  } isect_t;
endpackage

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for line_intersection_params.
// Drives random and directed segment pairs, predicts Q16.16 parameters by exact
// long division, and checks every result word in order. Depends on lip_if, tb_lip_types.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #2 clk = ~clk;

  lip_in_if  pairs (clk);
  lip_out_if result (clk);

  line_intersection_params u_top (.clk(clk), .rst(rst), .pairs(pairs), .result(result));

  tb_lip_types::isect_t expected_q[$];
  int     mismatches = 0;
  int     n_sent = 0, n_got = 0, n_parallel = 0, n_clip = 0;
  bit     sink_idle_en = 1'b1;
  bit     src_idle_en = 1'b1;
  int     hold_cycles = 0;

  // quotient num/den in Q16.16, truncated toward zero, saturated
  function automatic logic [31:0] q16_div(longint num, longint den, ref bit clip);
    bit      neg;
    longint  an, ad, q, r, lim;
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    lim = neg ? 64'sh8000_0000 : 64'sh7FFF_FFFF;
    q = an / ad;
    r = an % ad;
    for (int i = 0; i < 16; i++) begin
      if (q > lim) break;
      q = q << 1;
      r = r << 1;
      if (r >= ad) begin
        r = r - ad;
        q = q + 1;
      end
    end
    if (q > lim) begin
      clip = 1'b1;
      q = lim;
    end
    return neg ? 32'(-q) : 32'(q);
  endfunction

  function automatic tb_lip_types::isect_t solve_pair(tb_lip_types::pair_t p);
    tb_lip_types::isect_t o;
    longint vax, vay, vbx, vby, dx, dy, det;
    bit clip;
    clip = 1'b0;
    vax = longint'(p.aex) - p.asx;
    vay = longint'(p.aey) - p.asy;
    vbx = longint'(p.bex) - p.bsx;
    vby = longint'(p.bey) - p.bsy;
    dx  = longint'(p.bsx) - p.asx;
    dy  = longint'(p.bsy) - p.asy;
    det = vbx * vay - vax * vby;
    o = '0;
    if (det != 0) begin
      o.found = 1'b1;
      o.pa = q16_div(vbx * dy - dx * vby, det, clip);
      o.pb = q16_div(vax * dy - dx * vay, det, clip);
      o.clipped = clip;
    end
    return o;
  endfunction

  // valid stays high after an accept so the next word can follow at once
  task automatic send_pair(tb_lip_types::pair_t p);
    if (src_idle_en) begin
      while ($urandom_range(99) < 15) begin
        pairs.valid <= 1'b0;
        @(posedge clk);
      end
    end
    pairs.valid <= 1'b1;
    {pairs.a_start_x, pairs.a_start_y, pairs.a_end_x, pairs.a_end_y,
     pairs.b_start_x, pairs.b_start_y, pairs.b_end_x, pairs.b_end_y} <= p;
    do @(posedge clk); while (!pairs.ready);
    expected_q.push_back(solve_pair(p));
    n_sent++;
  endtask

  task automatic src_idle();
    pairs.valid <= 1'b0;
    @(posedge clk);
  endtask

  // result ready with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      result.ready <= 1'b0;
    end else result.ready <= !(sink_idle_en && $urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    tb_lip_types::isect_t got, exp_r;
    if (!rst && result.valid && result.ready) begin
      got = '{result.found, result.param_a, result.param_b, result.clipped};
      n_got++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (!exp_r.found) n_parallel++;
        if (exp_r.clipped) n_clip++;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp found=%0b a=%h b=%h clip=%0b got found=%0b a=%h b=%h clip=%0b",
                     exp_r.found, exp_r.pa, exp_r.pb, exp_r.clipped,
                     got.found, got.pa, got.pb, got.clipped);
        end
      end
    end
  end

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(4))
      0: return 16'(1 << $urandom_range(15)) ^ {16{$urandom_range(1) == 1}};
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      2: return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tb_lip_types::pair_t rnd_pair();
    tb_lip_types::pair_t p;
    p = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
         rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
    case ($urandom_range(9))
      0: begin  // parallel: B direction copies A direction
        p.bex = p.bsx + (p.aex - p.asx);
        p.bey = p.bsy + (p.aey - p.asy);
      end
      1: begin  // nearly parallel, large parameters
        p.bex = p.bsx + (p.aex - p.asx) + 16'($urandom_range(1));
        p.bey = p.bsy + (p.aey - p.asy);
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic test_directed();
    send_pair('{16'sd0, 16'sd0, 16'sd2, 16'sd2, 16'sd0, 16'sd2, 16'sd2, 16'sd0});
    send_pair('{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1});
    send_pair('{16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3});
    send_pair('{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000});
    send_pair('{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF});
    send_pair('{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF});
    send_pair('{16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sh8000, 16'sh7FFF, 16'sh8001, 16'sh7FFF});
    send_pair('{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sh8000, 16'sd0, 16'sh7FFF, 16'sd1});
    send_pair('{16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd1});
    send_pair('{16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd1, 16'sd1, 16'sd1, 16'sd4});
    send_pair('{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sh8000, 16'sd1, 16'sh8000, 16'sd2});
    send_pair('{16'sd0, 16'sd0, 16'sd2, 16'sd2, 16'sd5, 16'sd5, 16'sd9, 16'sd9});
    // exactly -2^31 must not clip: param -32768 along line A
    send_pair('{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sh8000, 16'sd0, 16'sh8000, 16'sd1});
  endtask

  task automatic test_random(int count);
    repeat (count) send_pair(rnd_pair());
  endtask

  task automatic test_backpressure();
    hold_cycles <= 300;
    src_idle_en = 1'b0;
    repeat (80) send_pair(rnd_pair());
    src_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    src_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) send_pair(rnd_pair());
  endtask

  task automatic test_no_idle();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (200) send_pair(rnd_pair());
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  initial begin
    pairs.valid <= 1'b0;
    {pairs.a_start_x, pairs.a_start_y, pairs.a_end_x, pairs.a_end_y,
     pairs.b_start_x, pairs.b_start_y, pairs.b_end_x, pairs.b_end_y} <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600);
    test_backpressure();
    test_drain_pause();
    test_no_idle();
    test_random(700);
    src_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d pairs, %0d results: %0d parallel, %0d saturated",
             n_sent, n_got, n_parallel, n_clip);
    if (mismatches == 0 && expected_q.size() == 0) $display("PASS line_intersection_params");
    else $display("FAIL line_intersection_params");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL line_intersection_params");
    $finish;
  end
endmodule
